// ----- rtl/rmez_pkg.sv -----
// Shared types, constants and helpers of the ZYX Euler angle converter.
package rmez_pkg;

    localparam int CW = 30;                 // CORDIC x/y datapath width
    localparam int AW = 21;                 // CORDIC angle width, 2^-16 rad
    localparam int SW = 32;                 // square root datapath width
    localparam int SQ_STEPS = 16;           // one root bit per stage

    localparam logic signed [AW-1:0] PI_Q16 = 21'sd205887;
    localparam logic signed [17:0] PI_Q13 = 18'sd25736;
    localparam logic signed [17:0] HALF_PI_Q13 = 18'sd12868;
    localparam logic signed [15:0] ONE_Q14 = 16'sd16384;

    typedef enum logic [1:0] {
        MODE_NORMAL    = 2'd0,
        MODE_LOCK_LOW  = 2'd1,
        MODE_LOCK_HIGH = 2'd2
    } mode_t;

    // Atan2 operands carried beside the square root.
    typedef struct packed {
        mode_t              mode;
        logic signed [16:0] y_num;   // -r20
        logic signed [16:0] z_num;
        logic signed [16:0] z_den;
        logic signed [16:0] x_num;
        logic signed [16:0] x_den;
    } side_t;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [AW-1:0] ang;
    } lane_t;

    // atan(2^-i) in 2^-16 rad, rounded.
    function automatic logic signed [AW-1:0] atan_tab(input int i);
        logic signed [AW-1:0] t;
        case (i)
            0:  t = 21'sd51472;
            1:  t = 21'sd30386;
            2:  t = 21'sd16055;
            3:  t = 21'sd8150;
            4:  t = 21'sd4091;
            5:  t = 21'sd2047;
            6:  t = 21'sd1024;
            7:  t = 21'sd512;
            8:  t = 21'sd256;
            9:  t = 21'sd128;
            10: t = 21'sd64;
            11: t = 21'sd32;
            12: t = 21'sd16;
            13: t = 21'sd8;
            14: t = 21'sd4;
            15: t = 21'sd2;
            16: t = 21'sd1;
            default: t = '0;
        endcase
        return t;
    endfunction

    // Scale by 256 and fold the left half plane onto the right.
    function automatic lane_t cordic_pre(input logic signed [16:0] num,
                                         input logic signed [16:0] den);
        lane_t l;
        logic signed [CW-1:0] xs;
        logic signed [CW-1:0] ys;
        xs = CW'(den) <<< 8;
        ys = CW'(num) <<< 8;
        if (den < 0) begin
            l.x = -xs;
            l.y = -ys;
            l.ang = (num >= 0) ? PI_Q16 : -PI_Q16;
        end else begin
            l.x = xs;
            l.y = ys;
            l.ang = '0;
        end
        return l;
    endfunction

    // Round to Q3.13 and clamp to +-pi.
    function automatic logic signed [15:0] cordic_post(input logic signed [AW-1:0] ang);
        logic signed [AW-1:0] r;
        logic signed [AW-1:0] lim;
        r = (ang + AW'(4)) >>> 3;
        lim = AW'(PI_Q13);
        if (r > lim) begin
            r = lim;
        end else if (r < -lim) begin
            r = -lim;
        end
        return r[15:0];
    endfunction

endpackage

// ----- rtl/rmez_isqrt_stage.sv -----
// One stage of the pipelined digit-by-digit integer square root.
module rmez_isqrt_stage #(
    parameter int K = 0
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  logic               vld_in,
    input  logic [31:0]        v_in,
    input  logic [31:0]        res_in,
    input  rmez_pkg::side_t    side_in,
    output logic               vld_reg,
    output logic [31:0]        v_reg,
    output logic [31:0]        res_reg,
    output rmez_pkg::side_t    side_reg
);
    import rmez_pkg::*;

    localparam logic [SW-1:0] BIT = SW'(1) << (2 * K);

    logic [SW-1:0] trial;
    logic [SW-1:0] v_next;
    logic [SW-1:0] res_next;

    always_comb begin
        trial = res_in + BIT;
        if (v_in >= trial) begin
            v_next = v_in - trial;
            res_next = (res_in >> 1) + BIT;
        end else begin
            v_next = v_in;
            res_next = res_in >> 1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (en) begin
            vld_reg <= vld_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            v_reg <= v_next;
            res_reg <= res_next;
            side_reg <= side_in;
        end
    end

endmodule

// ----- rtl/rmez_cordic_stage.sv -----
// One vectoring CORDIC micro-rotation with its register.
module rmez_cordic_stage #(
    parameter int I = 0
) (
    input  logic             aclk,
    input  logic             en,
    input  rmez_pkg::lane_t  lane_in,
    output rmez_pkg::lane_t  lane_reg
);
    import rmez_pkg::*;

    lane_t lane_next;
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;

    always_comb begin
        dx = lane_in.y >>> I;
        dy = lane_in.x >>> I;
        lane_next = lane_in;
        if (lane_in.y > 0) begin
            lane_next.x = lane_in.x + dx;
            lane_next.y = lane_in.y - dy;
            lane_next.ang = lane_in.ang + atan_tab(I);
        end else if (lane_in.y < 0) begin
            lane_next.x = lane_in.x - dx;
            lane_next.y = lane_in.y + dy;
            lane_next.ang = lane_in.ang - atan_tab(I);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            lane_reg <= lane_next;
        end
    end

endmodule

// ----- rtl/rotation_matrix_to_euler_zyx_core.sv -----
// Top level: rotation matrix to ZYX Euler angles, fully pipelined.
// Stages: input/square stage, 16 square root stages, pre-rotation,
//   CORDIC and output.
// Throughput: one item per cycle; the whole pipeline advances together and
//   holds while the output register is full and not taken.
// Reset: aresetn (synchronous, active low) clears all valid bits only.
module rotation_matrix_to_euler_zyx_core #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic signed [15:0]  s_row0_col0,
    input  logic signed [15:0]  s_row1_col0,
    input  logic signed [15:0]  s_row2_col0,
    input  logic signed [15:0]  s_row1_col1,
    input  logic signed [15:0]  s_row1_col2,
    input  logic signed [15:0]  s_row2_col1,
    input  logic signed [15:0]  s_row2_col2,
    output logic                m_valid,
    input  logic                m_ready,
    output logic signed [15:0]  m_angle_about_x,
    output logic signed [14:0]  m_angle_about_y,
    output logic signed [15:0]  m_angle_about_z
);
    import rmez_pkg::*;

    // Lanes: 0 = y (asin), 1 = z, 2 = x.
    localparam int NL = 3;

    // Advance everything when the output slot is free or being emptied.
    logic en;
    assign en = !m_valid || m_ready;
    assign s_ready = en;

    // Stage A: square r20, pick the case, set up atan2 operands.
    side_t side_next;
    logic [SW-1:0] rem_next;
    logic signed [31:0] sq;

    always_comb begin
        sq = s_row2_col0 * s_row2_col0;
        rem_next = SW'(32'd1 << 28) - SW'(sq);
        side_next.y_num = -17'(s_row2_col0);
        side_next.x_num = 17'(s_row2_col1);
        side_next.x_den = 17'(s_row2_col2);
        if (s_row2_col0 <= -ONE_Q14) begin
            side_next.mode = MODE_LOCK_LOW;
            side_next.z_num = -17'(s_row1_col2);
            side_next.z_den = 17'(s_row1_col1);
        end else if (s_row2_col0 >= ONE_Q14) begin
            side_next.mode = MODE_LOCK_HIGH;
            side_next.z_num = -17'(s_row1_col2);
            side_next.z_den = 17'(s_row1_col1);
        end else begin
            side_next.mode = MODE_NORMAL;
            side_next.z_num = 17'(s_row1_col0);
            side_next.z_den = 17'(s_row0_col0);
        end
    end

    logic          sq_vld [0:SQ_STEPS];
    logic [SW-1:0] sq_v   [0:SQ_STEPS];
    logic [SW-1:0] sq_res [0:SQ_STEPS];
    side_t         sq_side[0:SQ_STEPS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_vld[0] <= 1'b0;
        end else if (en) begin
            sq_vld[0] <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sq_v[0] <= rem_next;
            sq_res[0] <= '0;
            sq_side[0] <= side_next;
        end
    end

    // Square root of 1 - r20^2, one root bit per stage, highest first.
    for (genvar j = 0; j < SQ_STEPS; j++) begin : g_sqrt
        rmez_isqrt_stage #(.K(SQ_STEPS - 1 - j)) u_stage (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (en),
            .vld_in   (sq_vld[j]),
            .v_in     (sq_v[j]),
            .res_in   (sq_res[j]),
            .side_in  (sq_side[j]),
            .vld_reg  (sq_vld[j+1]),
            .v_reg    (sq_v[j+1]),
            .res_reg  (sq_res[j+1]),
            .side_reg (sq_side[j+1])
        );
    end

    // Pre-rotation stage, then CORDIC_STEPS micro-rotations per lane.
    lane_t cl    [NL][0:CORDIC_STEPS];
    logic  cv_reg[0:CORDIC_STEPS];
    mode_t cm_reg[0:CORDIC_STEPS];
    side_t ps;
    logic signed [16:0] root;

    assign ps = sq_side[SQ_STEPS];
    assign root = 17'(sq_res[SQ_STEPS][16:0]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cv_reg[0] <= 1'b0;
        end else if (en) begin
            cv_reg[0] <= sq_vld[SQ_STEPS];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cm_reg[0] <= ps.mode;
            cl[0][0] <= cordic_pre(ps.y_num, root);
            cl[1][0] <= cordic_pre(ps.z_num, ps.z_den);
            cl[2][0] <= cordic_pre(ps.x_num, ps.x_den);
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                cv_reg[i+1] <= 1'b0;
            end else if (en) begin
                cv_reg[i+1] <= cv_reg[i];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                cm_reg[i+1] <= cm_reg[i];
            end
        end

        for (genvar l = 0; l < NL; l++) begin : g_lane
            rmez_cordic_stage #(.I(i)) u_stage (
                .aclk     (aclk),
                .en       (en),
                .lane_in  (cl[l][i]),
                .lane_reg (cl[l][i+1])
            );
        end
    end

    // Output stage: round, clamp, apply the gimbal lock rules.
    logic signed [15:0] ay_full;
    logic signed [15:0] az_full;
    logic signed [15:0] ax_full;
    logic signed [15:0] ax_next;
    logic signed [14:0] ay_next;
    logic signed [15:0] az_next;
    logic               m_valid_reg;
    logic signed [15:0] ax_reg;
    logic signed [14:0] ay_reg;
    logic signed [15:0] az_reg;

    always_comb begin
        ay_full = cordic_post(cl[0][CORDIC_STEPS].ang);
        az_full = cordic_post(cl[1][CORDIC_STEPS].ang);
        ax_full = cordic_post(cl[2][CORDIC_STEPS].ang);
        case (cm_reg[CORDIC_STEPS])
            MODE_LOCK_LOW: begin
                ax_next = '0;
                ay_next = 15'(HALF_PI_Q13);
                az_next = -az_full;
            end
            MODE_LOCK_HIGH: begin
                ax_next = '0;
                ay_next = -15'(HALF_PI_Q13);
                az_next = az_full;
            end
            default: begin
                ax_next = ax_full;
                az_next = az_full;
                if (ay_full > 16'(HALF_PI_Q13)) begin
                    ay_next = 15'(HALF_PI_Q13);
                end else if (ay_full < -16'(HALF_PI_Q13)) begin
                    ay_next = -15'(HALF_PI_Q13);
                end else begin
                    ay_next = ay_full[14:0];
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= cv_reg[CORDIC_STEPS];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ax_reg <= ax_next;
            ay_reg <= ay_next;
            az_reg <= az_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_angle_about_x = ax_reg;
    assign m_angle_about_y = ay_reg;
    assign m_angle_about_z = az_reg;

endmodule

// ----- bench/tb_rotation_matrix_to_euler_zyx_core.sv -----
// Testbench for the rotation matrix to ZYX Euler angle converter.
module tb_rotation_matrix_to_euler_zyx_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STEPS = 16;
    localparam int LATENCY = STEPS + 19;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int ONE = 16384;

    typedef struct {
        logic signed [15:0] r00, r10, r20, r11, r12, r21, r22;
    } matrix_t;

    typedef struct {
        logic signed [15:0] ax;
        logic signed [14:0] ay;
        logic signed [15:0] az;
    } angles_t;

    int mismatches = 0;

    // One line per mismatch, counted for the final verdict.
    task automatic report_mismatch(input string what);
        mismatches++;
        $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    // Vectoring CORDIC atan2, result in Q3.13 clamped to +-pi.
    function automatic longint angle_of(input longint y, input longint x);
        longint tab[17] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                            256, 128, 64, 32, 16, 8, 4, 2, 1};
        longint ang, dx, dy, r;
        ang = 0;
        x = x * 256;
        y = y * 256;
        if (x < 0) begin
            ang = (y >= 0) ? 205887 : -205887;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0) begin
                x += dx;
                y -= dy;
                ang += (i < 17) ? tab[i] : 0;
            end else if (y < 0) begin
                x -= dx;
                y += dy;
                ang -= (i < 17) ? tab[i] : 0;
            end
        end
        r = (ang + 4) >>> 3;
        if (r > 25736) r = 25736;
        if (r < -25736) r = -25736;
        return r;
    endfunction

    function automatic longint floor_root(input longint v);
        longint res, b;
        res = 0;
        b = 64'd1 << 30;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    function automatic angles_t euler_of(input matrix_t m);
        angles_t a;
        longint r20, c, t;
        r20 = m.r20;
        if (r20 <= -ONE) begin
            a.ay = 15'sd12868;
            a.az = 16'(-angle_of(-longint'(m.r12), m.r11));
            a.ax = '0;
        end else if (r20 >= ONE) begin
            a.ay = -15'sd12868;
            a.az = 16'(angle_of(-longint'(m.r12), m.r11));
            a.ax = '0;
        end else begin
            c = floor_root((64'd1 << 28) - r20 * r20);
            // Clamp the y angle to +-pi/2.
            t = angle_of(-r20, c);
            if (t > 12868) t = 12868;
            if (t < -12868) t = -12868;
            a.ay = 15'(t);
            a.az = 16'(angle_of(m.r10, m.r00));
            a.ax = 16'(angle_of(m.r21, m.r22));
        end
        return a;
    endfunction

    // Holds expected angle triples in acceptance order.
    class angle_scoreboard;
        angles_t pending[$];
        int matrices_in = 0;
        int results_out = 0;

        function void note_matrix(input matrix_t m);
            pending.push_back(euler_of(m));
            matrices_in++;
        endfunction

        task check_result(input angles_t got);
            angles_t want;
            results_out++;
            if (pending.size() == 0) begin
                report_mismatch("result with no matrix outstanding");
                return;
            end
            want = pending.pop_front();
            if (got.ax !== want.ax)
                report_mismatch($sformatf("x angle %0d, want %0d", got.ax, want.ax));
            if (got.ay !== want.ay)
                report_mismatch($sformatf("y angle %0d, want %0d", got.ay, want.ay));
            if (got.az !== want.az)
                report_mismatch($sformatf("z angle %0d, want %0d", got.az, want.az));
        endtask
    endclass

    angle_scoreboard board = new();

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [15:0] s_row0_col0 = '0, s_row1_col0 = '0, s_row2_col0 = '0;
    logic signed [15:0] s_row1_col1 = '0, s_row1_col2 = '0;
    logic signed [15:0] s_row2_col1 = '0, s_row2_col2 = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [15:0] m_angle_about_x;
    logic signed [14:0] m_angle_about_y;
    logic signed [15:0] m_angle_about_z;

    // Percent of cycles each side idles; hold_off forces a long output stall.
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    bit hold_off = 1'b0;
    int idle_cycles = 0;

    always begin
        aclk = 1'b1;
        #4;
        aclk = 1'b0;
        #4;
    end

    rotation_matrix_to_euler_zyx_core #(.CORDIC_STEPS(STEPS)) u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_row0_col0(s_row0_col0), .s_row1_col0(s_row1_col0),
        .s_row2_col0(s_row2_col0), .s_row1_col1(s_row1_col1),
        .s_row1_col2(s_row1_col2), .s_row2_col1(s_row2_col1),
        .s_row2_col2(s_row2_col2),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_angle_about_x(m_angle_about_x), .m_angle_about_y(m_angle_about_y),
        .m_angle_about_z(m_angle_about_z)
    );

    // Sample both channels at the rising edge; record accepted items.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                matrix_t m;
                m.r00 = s_row0_col0; m.r10 = s_row1_col0; m.r20 = s_row2_col0;
                m.r11 = s_row1_col1; m.r12 = s_row1_col2;
                m.r21 = s_row2_col1; m.r22 = s_row2_col2;
                board.note_matrix(m);
            end
            if (m_valid && m_ready) begin
                angles_t a;
                a.ax = m_angle_about_x;
                a.ay = m_angle_about_y;
                a.az = m_angle_about_z;
                board.check_result(a);
            end
            if ((s_valid && s_ready) || (m_valid && m_ready) || hold_off)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // Watchdog: end the run if nothing moves for too long.
    always @(posedge aclk) begin
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired, %0d results outstanding", board.pending.size());
            $display("FAILURE");
            $finish;
        end
    end

    // Drive the receiver: random stall unless held off entirely.
    always @(negedge aclk) begin
        if (hold_off)
            m_ready <= 1'b0;
        else
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Offer one matrix, with a random gap first, and hold it until taken.
    // Valid stays high afterwards; the caller drops it when the sender stops.
    task automatic send_matrix(input matrix_t m);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_row0_col0 <= m.r00; s_row1_col0 <= m.r10; s_row2_col0 <= m.r20;
        s_row1_col1 <= m.r11; s_row1_col2 <= m.r12;
        s_row2_col1 <= m.r21; s_row2_col2 <= m.r22;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // Pick an element value: extremes, around +-1.0, near zero, or anything.
    function automatic logic signed [15:0] pick_element();
        case ($urandom_range(5))
            0: return 16'(ONE + $urandom_range(8) - 4);
            1: return 16'(-ONE + $urandom_range(8) - 4);
            2: return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
            3: return 16'($urandom_range(64) - 32);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic matrix_t random_matrix();
        matrix_t m;
        m.r00 = pick_element(); m.r10 = pick_element();
        m.r11 = pick_element(); m.r12 = pick_element();
        m.r21 = pick_element(); m.r22 = pick_element();
        // Mostly in the normal range, sometimes at or past gimbal lock.
        if ($urandom_range(3) == 0)
            m.r20 = pick_element();
        else
            m.r20 = 16'($urandom_range(2 * ONE - 2) - (ONE - 1));
        return m;
    endfunction

    function automatic matrix_t make_matrix(input int a, b, c, d, e, f, g);
        matrix_t m;
        m.r00 = 16'(a); m.r10 = 16'(b); m.r20 = 16'(c);
        m.r11 = 16'(d); m.r12 = 16'(e); m.r21 = 16'(f); m.r22 = 16'(g);
        return m;
    endfunction

    task automatic wait_drained();
        while (board.pending.size() != 0) @(posedge aclk);
        @(negedge aclk);
    endtask

    int phase_pct[4][2] = '{'{0, 0}, '{56, 0}, '{0, 56}, '{38, 38}};

    initial begin
        matrix_t directed[$];
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: identity, zero vectors, extremes, both gimbal locks,
        // negative denominators with positive and negative numerators.
        directed.push_back(make_matrix(ONE, 0, 0, ONE, 0, 0, ONE));
        directed.push_back(make_matrix(0, 0, 0, 0, 0, 0, 0));
        directed.push_back(make_matrix(-ONE, 0, 0, -ONE, 0, 0, -ONE));
        directed.push_back(make_matrix(-ONE, -1, 0, 0, 0, -1, -ONE));
        directed.push_back(make_matrix(32767, 32767, 32767, 32767, 32767, 32767, 32767));
        directed.push_back(make_matrix(-32768, -32768, -32768, -32768, -32768,
                                       -32768, -32768));
        directed.push_back(make_matrix(0, ONE, -ONE, ONE, 0, 0, 0));
        directed.push_back(make_matrix(0, ONE, ONE, ONE, 0, 0, 0));
        directed.push_back(make_matrix(0, 0, -ONE, -ONE, ONE, 0, 0));
        directed.push_back(make_matrix(0, 0, ONE, -ONE, -ONE, 0, 0));
        directed.push_back(make_matrix(1, 1, ONE - 1, 1, 1, 1, 1));
        directed.push_back(make_matrix(1, -1, -ONE + 1, 1, 1, -1, 1));
        directed.push_back(make_matrix(0, 0, ONE + 1, 0, 0, 5, 5));
        directed.push_back(make_matrix(0, 0, -ONE - 1, 0, 0, 5, 5));
        directed.push_back(make_matrix(11585, 11585, -11585, 11585, -11585, 11585, -11585));
        directed.push_back(make_matrix(-32768, 32767, 0, 0, 0, 32767, -32768));
        foreach (directed[i]) send_matrix(directed[i]);
        s_valid <= 1'b0;
        wait_drained();

        // Random phases across the idling mixes.
        for (int p = 0; p < 4; p++) begin
            send_idle_pct = phase_pct[p][0];
            recv_stall_pct = phase_pct[p][1];
            repeat (240) send_matrix(random_matrix());
            s_valid <= 1'b0;
            // Pause the sender until every result is back.
            wait_drained();
        end

        // Long receiver hold-off while the sender keeps offering, so the
        // pipeline fills and input backs up.
        send_idle_pct = 0;
        recv_stall_pct = 0;
        fork
            begin
                hold_off = 1'b1;
                repeat (LATENCY * 3) @(negedge aclk);
                hold_off = 1'b0;
            end
            begin
                repeat (60) send_matrix(random_matrix());
                s_valid <= 1'b0;
            end
        join
        wait_drained();
        repeat (LATENCY + 5) @(posedge aclk);

        $display("covered %0d matrices (directed corners, gimbal lock, random)",
                 board.matrices_in);
        $display("checked %0d angle triples under four idling mixes and a long stall",
                 board.results_out);
        if (mismatches == 0 && board.pending.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule

// ----- filelist.f -----
rtl/rmez_pkg.sv
rtl/rmez_isqrt_stage.sv
rtl/rmez_cordic_stage.sv
rtl/rotation_matrix_to_euler_zyx_core.sv
bench/tb_rotation_matrix_to_euler_zyx_core.sv
